// ----- hdl/battery_fuel_gauge_core_assert.svh -----
// ----------------------------------------------------------------------------
// battery fuel gauge assertion macros
// shared property forms for the fuel gauge core checks
// ----------------------------------------------------------------------------
`ifndef BATTERY_FUEL_GAUGE_CORE_ASSERT_SVH
`define BATTERY_FUEL_GAUGE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define BFG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define BFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bfg_pkg.sv -----
// ----------------------------------------------------------------------------
// bfg_pkg
// types, constants, discharge curve and microcode program of the fuel gauge
// ----------------------------------------------------------------------------
package bfg_pkg;

  // program counter of the sequencer
  typedef logic [3:0] pc_t;

  // settle phase codes
  typedef enum logic [1:0] {
    PH_RESET  = 2'd0,
    PH_FORCE  = 2'd1,
    PH_SEARCH = 2'd2,
    PH_WALK   = 2'd3
  } phase_e;

  // reported battery state codes
  typedef enum logic [1:0] {
    BST_CHARGING    = 2'd0,
    BST_CHARGED     = 2'd1,
    BST_DISCHARGING = 2'd2,
    BST_LOW         = 2'd3
  } bstate_e;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SCALE,
    ACT_CAND_FULL,
    ACT_CAND_ONE,
    ACT_CAND_INC,
    ACT_CAND_STORED,
    ACT_CAND_DEC,
    ACT_COMMIT
  } act_e;

  // jump condition of one microcode step
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_BEAT,
    COND_PH_LOW,
    COND_PH_WALK,
    COND_SRCH_HIT,
    COND_WALK_HIT,
    COND_OUT_FREE
  } cond_e;

  // one control word: action, jump condition, target, hold when not taken
  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   jmp;
    logic  hold;
  } ctrl_word_t;

  // status flags from the datapath into the sequencer
  typedef struct packed {
    logic beat;
    logic ph_low;
    logic ph_walk;
    logic srch_hit;
    logic walk_hit;
    logic out_free;
  } cond_vec_t;

  // configuration register indexes
  localparam logic [1:0] CfgScale     = 2'd0;
  localparam logic [1:0] CfgThreshold = 2'd1;

  // register reset values
  localparam logic [15:0] ScaleReset     = 16'd7200;
  localparam logic [15:0] ThresholdReset = 16'd4250;

  localparam logic [6:0]  FullPercent = 7'd100;
  localparam logic [15:0] MvMax       = 16'hFFFF;

  // program step addresses
  localparam pc_t StepWait     = 4'd0;
  localparam pc_t StepScale    = 4'd1;
  localparam pc_t StepDispLow  = 4'd2;
  localparam pc_t StepDispWalk = 4'd3;
  localparam pc_t StepSrchInit = 4'd4;
  localparam pc_t StepSrch     = 4'd5;
  localparam pc_t StepWalkInit = 4'd6;
  localparam pc_t StepWalk     = 4'd7;
  localparam pc_t StepFull     = 4'd8;
  localparam pc_t StepCommit   = 4'd9;

  // discharge curve in mV, index is percent
  localparam logic [15:0] CurveMv [0:100] = '{
    16'd0,
    16'd3043, 16'd3269, 16'd3368, 16'd3437, 16'd3493, 16'd3536, 16'd3568, 16'd3596,
    16'd3621, 16'd3636, 16'd3655, 16'd3659, 16'd3662, 16'd3666, 16'd3669, 16'd3672,
    16'd3675, 16'd3678, 16'd3681, 16'd3684, 16'd3688, 16'd3691, 16'd3695, 16'd3698,
    16'd3702, 16'd3706, 16'd3710, 16'd3714, 16'd3718, 16'd3722, 16'd3725, 16'd3729,
    16'd3733, 16'd3737, 16'd3740, 16'd3744, 16'd3747, 16'd3751, 16'd3754, 16'd3757,
    16'd3760, 16'd3763, 16'd3765, 16'd3768, 16'd3771, 16'd3773, 16'd3776, 16'd3778,
    16'd3780, 16'd3783, 16'd3785, 16'd3788, 16'd3790, 16'd3793, 16'd3796, 16'd3798,
    16'd3801, 16'd3805, 16'd3808, 16'd3811, 16'd3815, 16'd3819, 16'd3823, 16'd3827,
    16'd3832, 16'd3836, 16'd3841, 16'd3846, 16'd3852, 16'd3857, 16'd3863, 16'd3868,
    16'd3874, 16'd3880, 16'd3886, 16'd3893, 16'd3899, 16'd3905, 16'd3911, 16'd3917,
    16'd3923, 16'd3929, 16'd3935, 16'd3941, 16'd3947, 16'd3953, 16'd3958, 16'd3964,
    16'd3969, 16'd3975, 16'd3981, 16'd3986, 16'd3993, 16'd3999, 16'd4006, 16'd4014,
    16'd4022, 16'd4031, 16'd4042, 16'd4050
  };

  // curve lookup, entries past full read as zero
  function automatic logic [15:0] curve_mv(logic [6:0] idx);
    logic [15:0] val;
    val = 16'd0;
    if (idx <= FullPercent) begin
      val = CurveMv[idx];
    end
    return val;
  endfunction

  // helper to build a control word
  function automatic ctrl_word_t cw(act_e act, cond_e cond, pc_t jmp, logic hold);
    ctrl_word_t w;
    w.act  = act;
    w.cond = cond;
    w.jmp  = jmp;
    w.hold = hold;
    return w;
  endfunction

  // microcode program
  function automatic ctrl_word_t ucode_rom(pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      StepWait:     w = cw(ACT_LOAD,        COND_BEAT,     StepScale,    1'b1);
      StepScale:    w = cw(ACT_SCALE,       COND_ALWAYS,   StepDispLow,  1'b0);
      StepDispLow:  w = cw(ACT_NONE,        COND_PH_LOW,   StepFull,     1'b0);
      StepDispWalk: w = cw(ACT_NONE,        COND_PH_WALK,  StepWalkInit, 1'b0);
      StepSrchInit: w = cw(ACT_CAND_ONE,    COND_ALWAYS,   StepSrch,     1'b0);
      StepSrch:     w = cw(ACT_CAND_INC,    COND_SRCH_HIT, StepCommit,   1'b1);
      StepWalkInit: w = cw(ACT_CAND_STORED, COND_ALWAYS,   StepWalk,     1'b0);
      StepWalk:     w = cw(ACT_CAND_DEC,    COND_WALK_HIT, StepCommit,   1'b1);
      StepFull:     w = cw(ACT_CAND_FULL,   COND_ALWAYS,   StepCommit,   1'b0);
      StepCommit:   w = cw(ACT_COMMIT,      COND_OUT_FREE, StepWait,     1'b1);
      default:      w = cw(ACT_NONE,        COND_ALWAYS,   StepWait,     1'b0);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/bfg_seq.sv -----
// ----------------------------------------------------------------------------
// bfg_seq
// microcode sequencer: step counter, program rom and conditional jumps
// ----------------------------------------------------------------------------
module bfg_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bfg_pkg::cond_vec_t     cond_i,
  output bfg_pkg::ctrl_word_t    cw_o
);

  bfg_pkg::pc_t        pc_q;
  bfg_pkg::pc_t        pc_d;
  bfg_pkg::ctrl_word_t cw;
  logic                taken;

  // fetch the current control word
  assign cw   = bfg_pkg::ucode_rom(pc_q);
  assign cw_o = cw;

  // evaluate the jump condition
  always_comb begin
    unique case (cw.cond)
      bfg_pkg::COND_ALWAYS:   taken = 1'b1;
      bfg_pkg::COND_BEAT:     taken = cond_i.beat;
      bfg_pkg::COND_PH_LOW:   taken = cond_i.ph_low;
      bfg_pkg::COND_PH_WALK:  taken = cond_i.ph_walk;
      bfg_pkg::COND_SRCH_HIT: taken = cond_i.srch_hit;
      bfg_pkg::COND_WALK_HIT: taken = cond_i.walk_hit;
      bfg_pkg::COND_OUT_FREE: taken = cond_i.out_free;
      default:                taken = 1'b1;
    endcase
  end

  // next step: jump, hold or fall through
  always_comb begin
    priority if (taken) begin
      pc_d = cw.jmp;
    end else if (cw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bfg_pkg::StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hdl/battery_fuel_gauge_core.sv -----
// ----------------------------------------------------------------------------
// battery_fuel_gauge_core
// adc count to millivolts and discharge-curve percentage with settle sequence
// ----------------------------------------------------------------------------
// One beat in, one beat out. The count is scaled to mV (count * scale >>
// ADC_BITS, saturated), then turned into a percentage by a microcoded
// sequencer over the 101-entry discharge curve, one curve entry per cycle.
// Forced-full phases give the full level; the upward search steps up from
// entry one to the first entry at or above the voltage or the limit; the
// downward walk goes down from the stored level to the first one not above it.
// A new beat is taken once the previous result sits in the output register, so
// the output may be stalled while the next item is already being worked on.
// Configuration writes are taken every cycle and must only be made while idle.
module battery_fuel_gauge_core #(
  parameter int ADC_BITS    = 12,
  parameter int CURVE_STEPS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // measurement input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] adc_count, [12] charge_done, [15:13] zero
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] level_percent, [22:7] voltage_mv, [23] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] battery_state, [2] level_updated
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "battery_fuel_gauge_core_assert.svh"

  localparam int SrchLimit = (CURVE_STEPS < 100) ? CURVE_STEPS : 100;

  bfg_pkg::ctrl_word_t cw;
  bfg_pkg::cond_vec_t  cond;

  // configuration registers
  logic [15:0] scale_q;
  logic [15:0] thr_q;

  // settle state
  bfg_pkg::phase_e phase_q;
  bfg_pkg::phase_e phase_d;
  logic [6:0]      stored_q;
  logic [6:0]      stored_d;

  // datapath registers
  logic [11:0] adc_q;
  logic        done_q;
  logic [15:0] mv_q;
  logic [6:0]  cand_q;

  // output register
  logic        m_valid_q;
  logic [23:0] m_data_q;
  logic [2:0]  m_user_q;

  logic        beat;
  logic        out_free;
  logic [27:0] prod;
  logic [27:0] prod_sh;
  logic [15:0] mv_sat;
  logic [15:0] cand_mv;
  logic [6:0]  stored_eff;
  logic [6:0]  stored_cap;
  logic        charger;
  logic        updated;
  logic [6:0]  level;
  logic [1:0]  bstate;

  // sequencer
  bfg_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .cw_o   (cw)
  );

  // handshakes
  assign s_axis_tready = (cw.act == bfg_pkg::ACT_LOAD);
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // scaling to millivolts with saturation
  assign prod    = 28'(adc_q) * 28'(scale_q);
  assign prod_sh = prod >> ADC_BITS;
  assign mv_sat  = (|prod_sh[27:16]) ? bfg_pkg::MvMax : prod_sh[15:0];

  // curve entry at the candidate
  assign cand_mv    = bfg_pkg::curve_mv(cand_q);
  assign stored_cap = (stored_q > bfg_pkg::FullPercent) ? bfg_pkg::FullPercent : stored_q;

  // conditions for the sequencer
  always_comb begin
    cond.beat     = beat;
    cond.ph_low   = (phase_q == bfg_pkg::PH_RESET) || (phase_q == bfg_pkg::PH_FORCE);
    cond.ph_walk  = (phase_q == bfg_pkg::PH_WALK);
    cond.srch_hit = (cand_q >= 7'(SrchLimit)) || (cand_mv >= mv_q);
    cond.walk_hit = (cand_q == 7'd0) || (mv_q >= cand_mv);
    cond.out_free = out_free;
  end

  // result and settle state update at commit
  always_comb begin
    stored_eff = (phase_q == bfg_pkg::PH_RESET) ? bfg_pkg::FullPercent : stored_q;
    charger    = mv_q > thr_q;
    updated    = (phase_q == bfg_pkg::PH_FORCE);
    stored_d   = stored_eff;
    unique case (phase_q)
      bfg_pkg::PH_RESET:  phase_d = bfg_pkg::PH_FORCE;
      bfg_pkg::PH_FORCE:  phase_d = bfg_pkg::PH_SEARCH;
      bfg_pkg::PH_SEARCH: phase_d = bfg_pkg::PH_WALK;
      bfg_pkg::PH_WALK:   phase_d = bfg_pkg::PH_WALK;
      default:            phase_d = bfg_pkg::PH_RESET;
    endcase
    if (charger) begin
      level   = bfg_pkg::FullPercent;
      bstate  = done_q ? bfg_pkg::BST_CHARGED : bfg_pkg::BST_CHARGING;
      phase_d = bfg_pkg::PH_RESET;
    end else begin
      if (cand_q < stored_eff) begin
        stored_d = cand_q;
        updated  = 1'b1;
      end
      level  = stored_d;
      bstate = (cand_q == 7'd0) ? bfg_pkg::BST_LOW : bfg_pkg::BST_DISCHARGING;
    end
  end

  // configuration and settle state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= bfg_pkg::ScaleReset;
      thr_q    <= bfg_pkg::ThresholdReset;
      phase_q  <= bfg_pkg::PH_RESET;
      stored_q <= bfg_pkg::FullPercent;
    end else begin
      if (cfg_valid_i && cfg_index_i == bfg_pkg::CfgScale) begin
        scale_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == bfg_pkg::CfgThreshold) begin
        thr_q <= cfg_data_i;
      end
      if (cw.act == bfg_pkg::ACT_COMMIT && out_free) begin
        phase_q  <= phase_d;
        stored_q <= stored_d;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cw.act == bfg_pkg::ACT_COMMIT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // datapath actions
  always_ff @(posedge clk_i) begin
    unique case (cw.act)
      bfg_pkg::ACT_LOAD: begin
        if (beat) begin
          adc_q  <= s_axis_tdata[11:0];
          done_q <= s_axis_tdata[12];
        end
      end
      bfg_pkg::ACT_SCALE:       mv_q   <= mv_sat;
      bfg_pkg::ACT_CAND_FULL:   cand_q <= bfg_pkg::FullPercent;
      bfg_pkg::ACT_CAND_ONE:    cand_q <= 7'd1;
      bfg_pkg::ACT_CAND_INC: begin
        if (!cond.srch_hit) begin
          cand_q <= cand_q + 7'd1;
        end
      end
      bfg_pkg::ACT_CAND_STORED: cand_q <= stored_cap;
      bfg_pkg::ACT_CAND_DEC: begin
        if (!cond.walk_hit) begin
          cand_q <= cand_q - 7'd1;
        end
      end
      bfg_pkg::ACT_COMMIT: begin
        if (out_free) begin
          m_data_q <= {1'b0, mv_q, level};
          m_user_q <= {updated, bstate};
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `BFG_ASSERT_NOW(a_level_range, m_axis_tvalid,
                  m_axis_tdata[6:0] <= bfg_pkg::FullPercent, "level above full")
  `BFG_ASSERT_NOW(a_low_is_empty, m_axis_tvalid && m_axis_tuser[1:0] == bfg_pkg::BST_LOW,
                  m_axis_tdata[6:0] == 7'd0, "low state with nonzero level")
  `BFG_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "beat taken while busy")
  `BFG_ASSERT_NOW(a_stored_range, 1'b1, stored_q <= bfg_pkg::FullPercent,
                  "stored level above full")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fuel gauge core: a scoreboard class predicts
// voltage, level, state and update flag for every measurement beat and
// checks each result beat in order, across several scale/threshold settings
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADC_SHIFT    = 12;
  localparam int SEARCH_STEPS = 100;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 170;

  // discharge curve in mV, index is percent
  localparam logic [15:0] DISCHARGE_MV [0:100] = '{
    16'd0,
    16'd3043, 16'd3269, 16'd3368, 16'd3437, 16'd3493, 16'd3536, 16'd3568, 16'd3596,
    16'd3621, 16'd3636, 16'd3655, 16'd3659, 16'd3662, 16'd3666, 16'd3669, 16'd3672,
    16'd3675, 16'd3678, 16'd3681, 16'd3684, 16'd3688, 16'd3691, 16'd3695, 16'd3698,
    16'd3702, 16'd3706, 16'd3710, 16'd3714, 16'd3718, 16'd3722, 16'd3725, 16'd3729,
    16'd3733, 16'd3737, 16'd3740, 16'd3744, 16'd3747, 16'd3751, 16'd3754, 16'd3757,
    16'd3760, 16'd3763, 16'd3765, 16'd3768, 16'd3771, 16'd3773, 16'd3776, 16'd3778,
    16'd3780, 16'd3783, 16'd3785, 16'd3788, 16'd3790, 16'd3793, 16'd3796, 16'd3798,
    16'd3801, 16'd3805, 16'd3808, 16'd3811, 16'd3815, 16'd3819, 16'd3823, 16'd3827,
    16'd3832, 16'd3836, 16'd3841, 16'd3846, 16'd3852, 16'd3857, 16'd3863, 16'd3868,
    16'd3874, 16'd3880, 16'd3886, 16'd3893, 16'd3899, 16'd3905, 16'd3911, 16'd3917,
    16'd3923, 16'd3929, 16'd3935, 16'd3941, 16'd3947, 16'd3953, 16'd3958, 16'd3964,
    16'd3969, 16'd3975, 16'd3981, 16'd3986, 16'd3993, 16'd3999, 16'd4006, 16'd4014,
    16'd4022, 16'd4031, 16'd4042, 16'd4050
  };

  // one predicted result beat
  typedef struct packed {
    logic [6:0]       level;
    bfg_pkg::bstate_e bstate;
    logic [15:0]      mv;
    logic             upd;
  } gauge_res_t;

  // gauge predictor and in-order result checker
  class gauge_scoreboard;
    logic [15:0]     scale;
    logic [15:0]     thresh;
    logic [6:0]      stored;
    bfg_pkg::phase_e phase;
    gauge_res_t      expected_q[$];
    int              errors;
    int              results;

    function new();
      scale   = bfg_pkg::ScaleReset;
      thresh  = bfg_pkg::ThresholdReset;
      stored  = bfg_pkg::FullPercent;
      phase   = bfg_pkg::PH_RESET;
      errors  = 0;
      results = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        bfg_pkg::CfgScale:     scale = data;
        bfg_pkg::CfgThreshold: thresh = data;
        default: ;
      endcase
    endfunction

    // predict the result of one accepted measurement beat
    function void note_input(logic [11:0] adc, logic done);
      logic [27:0] prod;
      int          cand;
      int          limit;
      gauge_res_t  res;
      prod  = (28'(adc) * 28'(scale)) >> ADC_SHIFT;
      res.mv = (prod > 28'hFFFF) ? 16'hFFFF : prod[15:0];
      res.upd = 1'b0;
      limit = (SEARCH_STEPS < 100) ? SEARCH_STEPS : 100;
      case (phase)
        bfg_pkg::PH_FORCE: begin
          cand    = 100;
          res.upd = 1'b1;
          phase   = bfg_pkg::PH_SEARCH;
        end
        bfg_pkg::PH_SEARCH: begin
          // first curve entry at or above the voltage, else the limit
          for (cand = 1; cand < limit; cand++) begin
            if (DISCHARGE_MV[cand] >= res.mv) break;
          end
          phase = bfg_pkg::PH_WALK;
        end
        bfg_pkg::PH_WALK: begin
          cand = (stored > bfg_pkg::FullPercent) ? 100 : int'(stored);
          while (cand > 0 && res.mv < DISCHARGE_MV[cand]) cand--;
        end
        default: begin
          cand   = 100;
          stored = bfg_pkg::FullPercent;
          phase  = bfg_pkg::PH_FORCE;
        end
      endcase
      // charger present overrides the level and restarts settling
      if (res.mv > thresh) begin
        res.bstate = done ? bfg_pkg::BST_CHARGED : bfg_pkg::BST_CHARGING;
        res.level  = bfg_pkg::FullPercent;
        phase      = bfg_pkg::PH_RESET;
      end else begin
        if (cand < stored) begin
          stored  = 7'(cand);
          res.upd = 1'b1;
        end
        res.level  = stored;
        res.bstate = (cand == 0) ? bfg_pkg::BST_LOW : bfg_pkg::BST_DISCHARGING;
      end
      expected_q.push_back(res);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic [6:0] level, logic [1:0] bst, logic [15:0] mv,
                               logic upd);
      gauge_res_t res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat level %0d state %0d mv %0d upd %0d",
                 $time, level, bst, mv, upd);
        errors++;
        return;
      end
      res = expected_q.pop_front();
      results++;
      if (level !== res.level) begin
        $display("%0t: level_percent expected %0d actual %0d", $time, res.level, level);
        errors++;
      end
      if (bst !== res.bstate) begin
        $display("%0t: battery_state expected %0d actual %0d", $time, res.bstate, bst);
        errors++;
      end
      if (mv !== res.mv) begin
        $display("%0t: voltage_mv expected %0d actual %0d", $time, res.mv, mv);
        errors++;
      end
      if (upd !== res.upd) begin
        $display("%0t: level_updated expected %0d actual %0d", $time, res.upd, upd);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = 16'd0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        steady = 1'b0;
  int          stall_cycles = 0;
  int          n_items = 0;
  int          n_writes = 0;
  int          n_settings = 0;

  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [23:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;
  wire         cfg_ready_o;

  gauge_scoreboard sb = new();

  battery_fuel_gauge_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),         // [11:0] adc_count, [12] charge_done, [15:13] zero
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),   // [6:0] level_percent, [22:7] voltage_mv, [23] zero
    .m_axis_tuser (m_axis_tuser),   // [1:0] battery_state, [2] level_updated
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      sb.check_result(m_axis_tdata[6:0], m_axis_tuser[1:0], m_axis_tdata[22:7],
                      m_axis_tuser[2]);
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, sb.outstanding());
        $display("** battery_fuel_gauge_core: FAILED **");
        $finish;
      end
    end
  end

  // one measurement beat, valid left high for a following beat
  task automatic send_meas(logic [11:0] adc, logic done);
    while (!steady && $urandom_range(0, 99) < 15) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {3'b000, done, adc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(adc, done);
    n_items++;
  endtask

  // one register write beat, valid left high for a following write
  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    n_writes++;
  endtask

  // stop driving and wait for every predicted result
  task automatic drain();
    s_valid   <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [15:0] scale, logic [15:0] thresh);
    write_cfg(bfg_pkg::CfgScale, scale);
    write_cfg(bfg_pkg::CfgThreshold, thresh);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // smallest count that reaches the target voltage at the current scale
  function automatic logic [11:0] count_for_mv(int unsigned target);
    int unsigned cnt;
    cnt = (target * 4096 + int'(sb.scale) - 1) / int'(sb.scale);
    if (cnt > 4095) cnt = 4095;
    return cnt[11:0];
  endfunction

  // mostly discharge runs with falling voltage, some charger beats and noise
  task automatic random_phase(int n);
    int          sent;
    int          run_len;
    int unsigned mv;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 15) begin
        send_meas(12'($urandom), 1'($urandom));
        sent++;
      end else begin
        run_len = $urandom_range(3, 20);
        mv = $urandom_range(2950, 4150);
        for (int i = 0; i < run_len; i++) begin
          send_meas(count_for_mv(mv), 1'($urandom));
          sent++;
          if (mv > 40) mv = mv - $urandom_range(0, 30);
        end
        if ($urandom_range(0, 1) == 1) begin
          send_meas(count_for_mv(int'(sb.thresh) + 1 + $urandom_range(0, 400)),
                    1'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, charger states, threshold edge, full walk to low
    send_meas(12'd0, 1'b0);
    send_meas(12'd4095, 1'b1);
    send_meas(12'd4095, 1'b0);
    send_meas(12'd2161, 1'b0);
    send_meas(12'd2161, 1'b0);
    send_meas(12'd2161, 1'b0);
    send_meas(12'd2100, 1'b0);
    send_meas(12'd1700, 1'b0);
    send_meas(12'd0, 1'b0);
    send_meas(12'd2400, 1'b1);
    send_meas(12'd2418, 1'b0);
    send_meas(12'd2419, 1'b1);
    drain();

    // directed: unused indexes, unity scale so counts equal mV
    write_cfg(2'd2, 16'($urandom));
    write_cfg(2'd3, 16'($urandom));
    apply_setting(16'd4096, 16'd4095);
    send_meas(12'd4095, 1'b0);
    send_meas(12'd4050, 1'b0);
    send_meas(12'd4050, 1'b0);
    send_meas(12'd4042, 1'b0);
    send_meas(12'd3043, 1'b0);
    send_meas(12'd3042, 1'b0);
    send_meas(12'd4095, 1'b0);
    drain();
    apply_setting(16'd4096, 16'd3000);
    send_meas(12'd3000, 1'b1);
    send_meas(12'd3001, 1'b0);
    drain();

    // random phases over several settings, extremes first
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(bfg_pkg::ScaleReset, bfg_pkg::ThresholdReset);
        1: apply_setting(16'hFFFF, 16'd0);
        2: apply_setting(16'd1, 16'hFFFF);
        3: apply_setting(16'hFFFF, 16'hFFFF);
        4: apply_setting(16'd7200, 16'd3900);
        default: apply_setting(16'($urandom_range(6000, 9000)),
                               16'($urandom_range(3500, 4400)));
      endcase
      if (p == 5) begin
        write_cfg(2'd3, 16'($urandom));
        cfg_valid <= 1'b0;
      end
      steady <= (p == 4);
      random_phase(PHASE_ITEMS);
      drain();
    end
    steady <= 1'b0;

    // let the block settle and catch any stray result
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      sb.errors++;
    end

    $display("run covered %0d measurements and %0d checked results", n_items, sb.results);
    $display("across %0d settings with %0d register writes, %0d mismatches", n_settings,
             n_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("** battery_fuel_gauge_core: PASSED **");
    end else begin
      $display("** battery_fuel_gauge_core: FAILED **");
    end
    $finish;
  end

endmodule
